// File: rtl/bounded_byte_stream_fifo_assert.svh
// assertion macros for the bounded byte stream fifo
`ifndef BOUNDED_BYTE_STREAM_FIFO_ASSERT_SVH
`define BOUNDED_BYTE_STREAM_FIFO_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define BBSF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bbsf assertion failed");
// condition never holds
`define BBSF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("bbsf assertion failed");
`else
`define BBSF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define BBSF_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: rtl/bbsf_pkg.sv
// shared types and constants of the bounded byte stream fifo
`timescale 1ns / 1ps
package bbsf_pkg;
	localparam int BYTE_W = 8;
	localparam int CNT_W = 13;
	localparam int REQ_W = 7;
	localparam int TOT_W = 32;
	localparam int MAX_BURST = 64;
	localparam int DQ_LOG2 = 2;
	localparam int OQ_LOG2 = 2;
	localparam logic [CNT_W-1:0] CAP_RESET = 13'd4096;

	typedef enum logic [2:0] {
		CMD_WRITE  = 3'd0,
		CMD_READ   = 3'd1,
		CMD_PEEK   = 3'd2,
		CMD_POP    = 3'd3,
		CMD_END    = 3'd4,
		CMD_STATUS = 3'd5
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] buffered;
		logic [CNT_W-1:0] remaining;
		logic [TOT_W-1:0] total_written;
		logic [TOT_W-1:0] total_read;
		logic             in_closed;
		logic             end_of_stream;
	} stat_t;

	typedef struct packed {
		logic             burst;
		logic             byte_valid;
		logic [REQ_W-1:0] n;
		logic [REQ_W-1:0] moved;
		stat_t            stat;
	} desc_t;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_value;
		logic              byte_valid;
		logic              last;
		logic [REQ_W-1:0]  moved_count;
		stat_t             stat;
	} res_t;
endpackage

// File: rtl/bbsf_fifo.sv
// small register queue used between the parts of the block
`timescale 1ns / 1ps
module bbsf_fifo #(
	parameter int WIDTH = 8,
	parameter int LOG2 = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic             full,
	output logic [LOG2:0]    level
);
	localparam int N = 2 ** LOG2;

	logic [WIDTH-1:0] mem_q [N];
	logic [LOG2-1:0]  wr_q;
	logic [LOG2-1:0]  rd_q;
	logic [LOG2:0]    level_q;
	logic             do_push;
	logic             do_pop;

	assign empty = (level_q == '0);
	assign full = (level_q == (LOG2+1)'(N));
	assign level = level_q;
	assign rdata = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			level_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end
endmodule

// File: rtl/bbsf_store.sv
// byte store: one write port, one registered read port
`timescale 1ns / 1ps
module bbsf_store #(
	parameter int DEPTH = 4096,
	localparam int PW = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [PW-1:0]             waddr,
	input  logic [bbsf_pkg::BYTE_W-1:0] wdata,
	input  logic                      re,
	input  logic [PW-1:0]             raddr,
	output logic [bbsf_pkg::BYTE_W-1:0] rdata
);
	import bbsf_pkg::*;

	logic [BYTE_W-1:0] mem_q [DEPTH];
	logic [BYTE_W-1:0] rdata_q;

	assign rdata = rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end
endmodule

// File: rtl/bbsf_front.sv
// front part: takes items, updates fill and totals, writes bytes to the store, issues descriptors
`timescale 1ns / 1ps
module bbsf_front #(
	parameter int DEPTH = 4096,
	localparam int PW = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [2:0]                  cmd,
	input  logic [bbsf_pkg::BYTE_W-1:0] data_byte,
	input  logic [bbsf_pkg::REQ_W-1:0]  count,
	input  logic                        cfg_wr_en,
	input  logic [bbsf_pkg::CNT_W-1:0]  cfg_wr_data,
	input  logic                        dq_full,
	output logic                        dq_push,
	output bbsf_pkg::desc_t             dq_desc,
	output logic [PW-1:0]               dq_addr,
	input  logic                        rd_done,
	output logic                        mem_we,
	output logic [PW-1:0]               mem_waddr,
	output logic [bbsf_pkg::BYTE_W-1:0] mem_wdata
);
	import bbsf_pkg::*;

	localparam int SW = ((PW > CNT_W) ? PW : CNT_W) + 1;
	localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
	localparam logic [CNT_W-1:0] CAP_LIM =
		CNT_W'((DEPTH > (2 ** CNT_W - 1)) ? (2 ** CNT_W - 1) : DEPTH);
	localparam logic [REQ_W-1:0] BURST_LIM = REQ_W'(MAX_BURST);
	localparam int BW = DQ_LOG2 + 1;

	logic              valid_s1;
	logic [2:0]        cmd_s1;
	logic [BYTE_W-1:0] data_s1;
	logic [REQ_W-1:0]  count_s1;

	logic [CNT_W-1:0] cap_q;
	logic [PW-1:0]    head_q;
	logic [CNT_W-1:0] fill_q;
	logic [TOT_W-1:0] wtot_q;
	logic [TOT_W-1:0] rtot_q;
	logic             ended_q;
	logic [BW-1:0]    rd_cnt_q;

	logic [CNT_W-1:0] eff_cap;
	logic [REQ_W-1:0] req;
	logic [REQ_W-1:0] n;
	logic [SW-1:0]    head_sum;
	logic [SW-1:0]    tail_sum;
	logic [PW-1:0]    head_adv;
	logic [PW-1:0]    tail;
	logic             write_ok;
	logic             adv;
	logic             accept;
	logic [PW-1:0]    head_n;
	logic [CNT_W-1:0] fill_n;
	logic [TOT_W-1:0] wtot_n;
	logic [TOT_W-1:0] rtot_n;
	logic             ended_n;
	logic             burst;
	logic             bv;
	logic [REQ_W-1:0] moved;
	logic             wr_en;

	// writes wait while a read or peek burst is still fetching, so freed slots are not reused early
	assign adv = valid_s1 && !dq_full &&
		!((cmd_s1 == CMD_WRITE) && (rd_cnt_q != '0));
	assign full = valid_s1 && !adv;
	assign accept = push && !full;

	always_comb begin
		eff_cap = (cap_q > CAP_LIM) ? CAP_LIM : cap_q;
		req = (count_s1 > BURST_LIM) ? BURST_LIM : count_s1;
		n = ((CNT_W)'(req) < fill_q) ? req : fill_q[REQ_W-1:0];
		head_sum = SW'(head_q) + SW'(n);
		head_adv = (head_sum >= DEPTH_S) ? PW'(head_sum - DEPTH_S) : PW'(head_sum);
		tail_sum = SW'(head_q) + SW'(fill_q);
		tail = (tail_sum >= DEPTH_S) ? PW'(tail_sum - DEPTH_S) : PW'(tail_sum);
		write_ok = fill_q < eff_cap;

		head_n = head_q;
		fill_n = fill_q;
		wtot_n = wtot_q;
		rtot_n = rtot_q;
		ended_n = ended_q;
		burst = 1'b0;
		bv = 1'b0;
		moved = '0;
		wr_en = 1'b0;
		unique case (cmd_s1)
			CMD_WRITE: begin
				if (write_ok) begin
					fill_n = fill_q + 1'b1;
					wtot_n = wtot_q + 1'b1;
					bv = 1'b1;
					wr_en = 1'b1;
				end
			end
			CMD_READ: begin
				burst = (n != '0);
				head_n = head_adv;
				fill_n = fill_q - CNT_W'(n);
				rtot_n = rtot_q + TOT_W'(n);
			end
			CMD_PEEK: begin
				burst = (n != '0);
			end
			CMD_POP: begin
				head_n = head_adv;
				fill_n = fill_q - CNT_W'(n);
				rtot_n = rtot_q + TOT_W'(n);
				moved = n;
			end
			CMD_END: begin
				ended_n = 1'b1;
			end
			default: begin
			end
		endcase

		dq_desc.burst = burst;
		dq_desc.byte_valid = bv;
		dq_desc.n = n;
		dq_desc.moved = moved;
		dq_desc.stat.buffered = fill_n;
		dq_desc.stat.remaining = (eff_cap > fill_n) ? (eff_cap - fill_n) : '0;
		dq_desc.stat.total_written = wtot_n;
		dq_desc.stat.total_read = rtot_n;
		dq_desc.stat.in_closed = ended_n;
		dq_desc.stat.end_of_stream = ended_n && (fill_n == '0);
	end

	assign dq_push = adv;
	assign dq_addr = head_q;
	assign mem_we = adv && wr_en;
	assign mem_waddr = tail;
	assign mem_wdata = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cap_q <= CAP_RESET;
			head_q <= '0;
			fill_q <= '0;
			wtot_q <= '0;
			rtot_q <= '0;
			ended_q <= 1'b0;
			rd_cnt_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (adv) begin
				head_q <= head_n;
				fill_q <= fill_n;
				wtot_q <= wtot_n;
				rtot_q <= rtot_n;
				ended_q <= ended_n;
			end
			if ((adv && burst) && !rd_done) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end else if (!(adv && burst) && rd_done) begin
				rd_cnt_q <= rd_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
			data_s1 <= data_byte;
			count_s1 <= count;
		end
	end
endmodule

// File: rtl/bbsf_back.sv
// back part: turns descriptors into result items, fetching bytes for bursts
`timescale 1ns / 1ps
module bbsf_back #(
	parameter int DEPTH = 4096,
	localparam int PW = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        dq_empty,
	input  bbsf_pkg::desc_t             dq_desc,
	input  logic [PW-1:0]               dq_addr,
	output logic                        dq_pop,
	output logic                        mem_re,
	output logic [PW-1:0]               mem_raddr,
	input  logic [bbsf_pkg::BYTE_W-1:0] mem_rdata,
	output logic                        rd_done,
	input  logic [bbsf_pkg::OQ_LOG2:0]  oq_level,
	input  logic                        oq_full,
	output logic                        oq_push,
	output bbsf_pkg::res_t              oq_item
);
	import bbsf_pkg::*;

	localparam int LW = OQ_LOG2 + 2;
	localparam logic [LW-1:0] OQ_N = LW'(2 ** OQ_LOG2);
	localparam logic [PW-1:0] LAST_ADDR = PW'(DEPTH - 1);

	logic             busy_q;
	logic [REQ_W-1:0] left_q;
	logic [PW-1:0]    addr_q;
	stat_t            stat_q;
	logic             pend_s1;
	logic             last_s1;

	logic room;
	logic issue;
	logic take;
	logic final_issue;

	// room for the byte in flight plus the one about to be fetched
	assign room = (LW'(oq_level) + LW'(pend_s1)) < OQ_N;
	assign issue = busy_q && room;
	assign final_issue = issue && (left_q == REQ_W'(1));
	assign take = !busy_q && !dq_empty && (dq_desc.burst || (!pend_s1 && !oq_full));
	assign dq_pop = take;
	assign mem_re = issue;
	assign mem_raddr = addr_q;
	assign rd_done = final_issue;
	assign oq_push = pend_s1 || (take && !dq_desc.burst);

	always_comb begin
		if (pend_s1) begin
			oq_item.byte_value = mem_rdata;
			oq_item.byte_valid = 1'b1;
			oq_item.last = last_s1;
			oq_item.moved_count = '0;
			oq_item.stat = stat_q;
		end else begin
			oq_item.byte_value = '0;
			oq_item.byte_valid = dq_desc.byte_valid;
			oq_item.last = 1'b1;
			oq_item.moved_count = dq_desc.moved;
			oq_item.stat = dq_desc.stat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= issue;
			if (take && dq_desc.burst) begin
				busy_q <= 1'b1;
			end else if (final_issue) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && dq_desc.burst) begin
			left_q <= dq_desc.n;
			addr_q <= dq_addr;
			stat_q <= dq_desc.stat;
		end else if (issue) begin
			left_q <= left_q - 1'b1;
			addr_q <= (addr_q == LAST_ADDR) ? '0 : (addr_q + 1'b1);
		end
		if (issue) begin
			last_s1 <= (left_q == REQ_W'(1));
		end
	end
endmodule

// File: rtl/bounded_byte_stream_fifo.sv
// top level of the bounded byte stream fifo
`timescale 1ns / 1ps
`include "bounded_byte_stream_fifo_assert.svh"
// usage
// - input side is a queue: drive cmd, data_byte, count with push; the item is
//   taken on a clock edge with push high and full low
// - result side is a queue: the oldest result item sits on the result ports
//   while empty is low and is taken on an edge with pop high
// - capacity is written through cfg_wr_en / cfg_wr_data only while idle; the user
//   must keep to this, as the block itself does not enforce it
// - a read or peek delivers one byte per cycle while the output queue has room
// - throughput: one item per cycle for writes, pops, status and end input while
//   the descriptor queue has room; a read or peek holds the byte fetcher until it
//   has fetched all its bytes, bounded by the single read port of the byte store
// - a write behind a read or peek waits until that burst has fetched all its bytes
// - every result item carries the fill, room and totals after its whole item
// - reset clears fill, head, totals and the ended flag and sets capacity to
//   4096; store contents are not cleared, only written bytes are ever read
// - when the receiver stalls, results collect in a small output queue, then
//   the fetcher stops, then the descriptor queue fills and full rises
module bounded_byte_stream_fifo #(
	parameter int DEPTH = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [2:0]                  cmd,
	input  logic [bbsf_pkg::BYTE_W-1:0] data_byte,
	input  logic [bbsf_pkg::REQ_W-1:0]  count,
	input  logic                        cfg_wr_en,
	input  logic [bbsf_pkg::CNT_W-1:0]  cfg_wr_data,
	output logic                        empty,
	input  logic                        pop,
	output logic [bbsf_pkg::BYTE_W-1:0] byte_value,
	output logic                        byte_valid,
	output logic                        last,
	output logic [bbsf_pkg::REQ_W-1:0]  moved_count,
	output logic [bbsf_pkg::CNT_W-1:0]  buffered,
	output logic [bbsf_pkg::CNT_W-1:0]  remaining,
	output logic [bbsf_pkg::TOT_W-1:0]  total_written,
	output logic [bbsf_pkg::TOT_W-1:0]  total_read,
	output logic                        in_closed,
	output logic                        end_of_stream
);
	import bbsf_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int DW = $bits(desc_t) + PW;

	// front to descriptor queue
	logic          dq_push;
	desc_t         dq_desc_in;
	logic [PW-1:0] dq_addr_in;
	logic          dq_full;
	logic [DW-1:0] dq_rdata;
	logic          dq_empty;
	logic          dq_pop;
	desc_t         dq_desc_out;
	logic [PW-1:0] dq_addr_out;

	// byte store ports
	logic              mem_we;
	logic [PW-1:0]     mem_waddr;
	logic [BYTE_W-1:0] mem_wdata;
	logic              mem_re;
	logic [PW-1:0]     mem_raddr;
	logic [BYTE_W-1:0] mem_rdata;

	// back to output queue
	logic           rd_done;
	logic           oq_push;
	res_t           oq_item;
	logic           oq_full;
	logic [OQ_LOG2:0] oq_level;
	res_t           res;

	bbsf_front #(.DEPTH(DEPTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.count       (count),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.dq_full     (dq_full),
		.dq_push     (dq_push),
		.dq_desc     (dq_desc_in),
		.dq_addr     (dq_addr_in),
		.rd_done     (rd_done),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata)
	);

	// descriptor queue decouples classification from byte delivery
	bbsf_fifo #(.WIDTH(DW), .LOG2(DQ_LOG2)) u_desc_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (dq_push),
		.wdata  ({dq_desc_in, dq_addr_in}),
		.pop    (dq_pop),
		.rdata  (dq_rdata),
		.empty  (dq_empty),
		.full   (dq_full),
		.level  ()
	);

	assign dq_desc_out = dq_rdata[DW-1:PW];
	assign dq_addr_out = dq_rdata[PW-1:0];

	bbsf_store #(.DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	bbsf_back #(.DEPTH(DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dq_empty  (dq_empty),
		.dq_desc   (dq_desc_out),
		.dq_addr   (dq_addr_out),
		.dq_pop    (dq_pop),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.rd_done   (rd_done),
		.oq_level  (oq_level),
		.oq_full   (oq_full),
		.oq_push   (oq_push),
		.oq_item   (oq_item)
	);

	// output queue of result items, lets the receiver stall; once it fills, intake backs up
	bbsf_fifo #(.WIDTH($bits(res_t)), .LOG2(OQ_LOG2)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (oq_push),
		.wdata  (oq_item),
		.pop    (pop),
		.rdata  (res),
		.empty  (empty),
		.full   (oq_full),
		.level  (oq_level)
	);

	assign byte_value = res.byte_value;
	assign byte_valid = res.byte_valid;
	assign last = res.last;
	assign moved_count = res.moved_count;
	assign buffered = res.stat.buffered;
	assign remaining = res.stat.remaining;
	assign total_written = res.stat.total_written;
	assign total_read = res.stat.total_read;
	assign in_closed = res.stat.in_closed;
	assign end_of_stream = res.stat.end_of_stream;

	// end of stream only with ended input and nothing held
	`BBSF_ASSERT_IMPLY(a_eos_consistent, clk, arst_n, !empty && end_of_stream, in_closed && (buffered == '0))
	// a pop result never carries a byte and always closes its item
	`BBSF_ASSERT_IMPLY(a_pop_shape, clk, arst_n, !empty && (moved_count != '0), !byte_valid && last)
	// fill plus room never exceeds the store size
	`BBSF_ASSERT_NEVER(a_room_bound, clk, arst_n, !empty && ((32'(buffered) + 32'(remaining)) > 32'(DEPTH)))
endmodule
